// ----- design/periodic_interval_timer_bank_unit_macros.svh -----
// Assertion helpers for the timer bank checks.
`ifndef PERIODIC_INTERVAL_TIMER_BANK_UNIT_MACROS_SVH
`define PERIODIC_INTERVAL_TIMER_BANK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PITB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PITB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");

`endif

// ----- design/pitb_pkg.sv -----
package pitb_pkg;

    localparam int ACT_W      = 2;
    localparam int PERIOD_W   = 32;
    localparam int ID_W       = 32;
    localparam int SLOT_W     = 5;
    localparam int TIME_W     = 64;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 64;
    localparam int M_FIELDS_W = ID_W + SLOT_W + TIME_W;
    localparam int M_TDATA_W  = 104;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Input action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SET,
        ST_CLEAR,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] elapsed;
        logic [ID_W-1:0]     ident;
    } entry_t;

    typedef struct packed {
        logic start_tick;
        logic start_set;
        logic start_clear;
        logic rd_en;
        logic proc_tick;
        logic proc_clear;
        logic set_take;
        logic set_full;
        logic emit_reply;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic slot_free;
    } stat_t;

endpackage

// ----- design/pitb_ctrl.sv -----
module pitb_ctrl #(
    parameter int SLOTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [pitb_pkg::ACT_W-1:0] action,
    output logic                       in_ready,
    input  pitb_pkg::stat_t            stat,
    output pitb_pkg::cmd_t             cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] walk_idx,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] proc_idx
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    pitb_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] proc_idx_reg, proc_idx_next;
    logic             rd_left_reg, rd_left_next;
    logic             proc_valid_reg, proc_valid_next;

    logic accept;
    logic walking;
    logic advance;
    logic at_last;

    assign accept  = in_valid && (state_reg == pitb_pkg::ST_IDLE);
    assign walking = (state_reg == pitb_pkg::ST_TICK) || (state_reg == pitb_pkg::ST_CLEAR);
    // A tick walk may emit an item, so hold it while the output is full
    assign advance = walking && ((state_reg == pitb_pkg::ST_CLEAR) || stat.out_free);
    assign at_last = (idx_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pitb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        pitb_pkg::ACT_TICK:  state_next = pitb_pkg::ST_TICK;
                        pitb_pkg::ACT_SET:   state_next = pitb_pkg::ST_SET;
                        pitb_pkg::ACT_CLEAR: state_next = pitb_pkg::ST_CLEAR;
                        default:             state_next = pitb_pkg::ST_IDLE;
                    endcase
                end
            end
            pitb_pkg::ST_TICK, pitb_pkg::ST_CLEAR:
            begin
                if (advance && !rd_left_reg)
                    state_next = pitb_pkg::ST_REPLY;
            end
            pitb_pkg::ST_SET:
            begin
                if (stat.slot_free || at_last)
                    state_next = pitb_pkg::ST_REPLY;
            end
            pitb_pkg::ST_REPLY:
            begin
                if (stat.out_free)
                    state_next = pitb_pkg::ST_IDLE;
            end
            default: state_next = pitb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            pitb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.start_tick  = (action == pitb_pkg::ACT_TICK);
                    cmd.start_set   = (action == pitb_pkg::ACT_SET);
                    cmd.start_clear = (action == pitb_pkg::ACT_CLEAR);
                end
            end
            pitb_pkg::ST_TICK:
            begin
                cmd.rd_en     = advance && rd_left_reg;
                cmd.proc_tick = advance && proc_valid_reg;
            end
            pitb_pkg::ST_CLEAR:
            begin
                cmd.rd_en      = advance && rd_left_reg;
                cmd.proc_clear = advance && proc_valid_reg;
            end
            pitb_pkg::ST_SET:
            begin
                cmd.set_take = stat.slot_free;
                cmd.set_full = !stat.slot_free && at_last;
            end
            pitb_pkg::ST_REPLY:
            begin
                cmd.emit_reply = stat.out_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        idx_next        = idx_reg;
        rd_left_next    = rd_left_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        if (accept)
        begin
            idx_next        = '0;
            rd_left_next    = 1'b1;
            proc_valid_next = 1'b0;
        end
        else if (advance)
        begin
            // Slot read this cycle moves to the process stage
            proc_valid_next = rd_left_reg;
            proc_idx_next   = idx_reg;
            if (rd_left_reg)
            begin
                idx_next     = idx_reg + 1'b1;
                rd_left_next = !at_last;
            end
        end
        else if ((state_reg == pitb_pkg::ST_SET) && !stat.slot_free && !at_last)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pitb_pkg::ST_IDLE;
            idx_reg        <= '0;
            rd_left_reg    <= 1'b0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rd_left_reg    <= rd_left_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
        end
    end

    assign in_ready = (state_reg == pitb_pkg::ST_IDLE);
    assign walk_idx = idx_reg;
    assign proc_idx = proc_idx_reg;

endmodule

// ----- design/pitb_dp.sv -----
module pitb_dp #(
    parameter int SLOTS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pitb_pkg::cmd_t                cmd,
    output pitb_pkg::stat_t               stat,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] walk_idx,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] proc_idx,
    input  logic [pitb_pkg::PERIOD_W-1:0] period_ms,
    input  logic [pitb_pkg::ID_W-1:0]     timer_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pitb_pkg::KIND_W-1:0]   kind,
    output logic [pitb_pkg::ID_W-1:0]     result_id,
    output logic [pitb_pkg::SLOT_W-1:0]   slot,
    output logic [pitb_pkg::TIME_W-1:0]   time_ms,
    output logic                          last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    pitb_pkg::entry_t mem [SLOTS];

    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] written_reg, written_next;
    logic [pitb_pkg::ID_W-1:0]   next_ident_reg;
    logic [pitb_pkg::TIME_W-1:0] tick_count_reg;

    pitb_pkg::entry_t rd_entry_reg;
    logic             rd_written_reg;

    logic [pitb_pkg::PERIOD_W-1:0] op_period_reg;
    pitb_pkg::kind_t               reply_kind_reg;
    logic [pitb_pkg::ID_W-1:0]     reply_id_reg;
    logic [pitb_pkg::SLOT_W-1:0]   reply_slot_reg;

    logic                          out_valid_reg;
    pitb_pkg::kind_t               out_kind_reg;
    logic [pitb_pkg::ID_W-1:0]     out_id_reg;
    logic [pitb_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [pitb_pkg::TIME_W-1:0]   out_time_reg;
    logic                          out_last_reg;

    pitb_pkg::entry_t              cur;
    pitb_pkg::entry_t              wr_data;
    logic [IDX_W-1:0]              wr_addr;
    logic                          wr_en;
    logic [pitb_pkg::PERIOD_W-1:0] cnt_up;
    logic                          counting;
    logic                          fire;
    logic                          match;
    logic                          out_free;
    logic [IDX_W+pitb_pkg::SLOT_W-1:0] proc_slot_ext;
    logic [IDX_W+pitb_pkg::SLOT_W-1:0] walk_slot_ext;

    assign proc_slot_ext = {{pitb_pkg::SLOT_W{1'b0}}, proc_idx};
    assign walk_slot_ext = {{pitb_pkg::SLOT_W{1'b0}}, walk_idx};

    // An entry never written reads as zero
    assign cur      = rd_written_reg ? rd_entry_reg : '0;
    assign cnt_up   = cur.elapsed + 1'b1;
    assign counting = active_reg[proc_idx] && (cur.period != '0);
    assign fire     = cmd.proc_tick && counting && (cnt_up >= cur.period);
    assign match    = cmd.proc_clear && (cur.ident == reply_id_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.out_free  = out_free;
    assign stat.slot_free = !active_reg[walk_idx];

    always_comb
    begin
        wr_en   = (cmd.proc_tick && counting) || cmd.set_take;
        wr_addr = cmd.set_take ? walk_idx : proc_idx;
        if (cmd.set_take)
            wr_data = '{period: op_period_reg, elapsed: '0, ident: next_ident_reg};
        else
            wr_data = '{period: cur.period, elapsed: (fire ? '0 : cnt_up), ident: cur.ident};
    end

    always_comb
    begin
        active_next  = active_reg;
        written_next = written_reg;
        if (cmd.set_take)
        begin
            active_next[walk_idx]  = 1'b1;
            written_next[walk_idx] = 1'b1;
        end
        if (match)
            active_next[proc_idx] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            rd_entry_reg   <= mem[walk_idx];
            rd_written_reg <= written_reg[walk_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            written_reg    <= '0;
            next_ident_reg <= pitb_pkg::ID_W'(1);
            tick_count_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            written_reg <= written_next;
            if (cmd.set_take)
                next_ident_reg <= next_ident_reg + 1'b1;
            if (cmd.start_tick)
                tick_count_reg <= tick_count_reg + 1'b1;
        end
    end

    // Set period and final reply of the current item, sent once the walk or probe is done
    always_ff @(posedge clk)
    begin
        if (cmd.start_set)
            op_period_reg <= period_ms;
        if (cmd.start_tick)
        begin
            reply_kind_reg <= pitb_pkg::KIND_TICK;
            reply_id_reg   <= '0;
            reply_slot_reg <= '0;
        end
        else if (cmd.start_clear)
        begin
            reply_kind_reg <= pitb_pkg::KIND_CLEAR;
            reply_id_reg   <= timer_id;
            reply_slot_reg <= '0;
        end
        else if (cmd.set_take)
        begin
            reply_kind_reg <= pitb_pkg::KIND_SET;
            reply_id_reg   <= next_ident_reg;
            reply_slot_reg <= walk_slot_ext[pitb_pkg::SLOT_W-1:0];
        end
        else if (cmd.set_full)
        begin
            reply_kind_reg <= pitb_pkg::KIND_SET;
            reply_id_reg   <= '0;
            reply_slot_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire || cmd.emit_reply)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_kind_reg <= pitb_pkg::KIND_FIRED;
            out_id_reg   <= cur.ident;
            out_slot_reg <= proc_slot_ext[pitb_pkg::SLOT_W-1:0];
            out_time_reg <= tick_count_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_reply)
        begin
            out_kind_reg <= reply_kind_reg;
            out_id_reg   <= reply_id_reg;
            out_slot_reg <= reply_slot_reg;
            out_time_reg <= tick_count_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign result_id = out_id_reg;
    assign slot      = out_slot_reg;
    assign time_ms   = out_time_reg;
    assign last      = out_last_reg;

endmodule

// ----- design/periodic_interval_timer_bank_unit.sv -----
// Bank of SLOTS periodic timers driven by a command stream.
// Input channel s_*: s_tuser carries the action (tick, set, clear, no-op),
// s_tdata carries period_ms and timer_id. One item is taken at a time;
// s_tready is high only while the bank is idle.
// Output channel m_*: m_tuser is the result kind, m_tdata holds result_id,
// slot and time_ms, m_tlast marks the final result of an input item.
// Tick: the slots are walked one per cycle while the output has room, through
// the single read port of the slot memory and then a process stage;
// fired items appear in slot order, then the tick-done item.
// Set: one active bit probed per cycle for a free slot.
// Clear: every stored id compared through the same read port.
// Action 3 is taken and gives no result.
// A registered output stage holds each result; while m_tready is low the
// tick walk holds and resumes when the item is taken. No result is dropped.
// Reset clears all active bits, the tick count and the id counter (next id 1);
// no clearing pass runs, the bank accepts items in the first cycle after reset.
module periodic_interval_timer_bank_unit #(
    parameter int SLOTS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pitb_pkg::S_TDATA_W-1:0]  s_tdata,  // period_ms, timer_id
    input  logic [pitb_pkg::ACT_W-1:0]      s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pitb_pkg::M_TDATA_W-1:0]  m_tdata,  // result_id, slot, time_ms, zero pad
    output logic [pitb_pkg::KIND_W-1:0]     m_tuser,  // kind
    output logic                            m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    pitb_pkg::cmd_t  cmd;
    pitb_pkg::stat_t stat;
    logic [IDX_W-1:0] walk_idx;
    logic [IDX_W-1:0] proc_idx;

    logic [pitb_pkg::PERIOD_W-1:0] period_ms;
    logic [pitb_pkg::ID_W-1:0]     timer_id;
    logic [pitb_pkg::ID_W-1:0]     result_id;
    logic [pitb_pkg::SLOT_W-1:0]   slot;
    logic [pitb_pkg::TIME_W-1:0]   time_ms;

    assign period_ms = s_tdata[pitb_pkg::PERIOD_W-1:0];
    assign timer_id  = s_tdata[pitb_pkg::PERIOD_W +: pitb_pkg::ID_W];

    pitb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .action   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd),
        .walk_idx (walk_idx),
        .proc_idx (proc_idx)
    );

    pitb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .walk_idx  (walk_idx),
        .proc_idx  (proc_idx),
        .period_ms (period_ms),
        .timer_id  (timer_id),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .kind      (m_tuser),
        .result_id (result_id),
        .slot      (slot),
        .time_ms   (time_ms),
        .last      (m_tlast)
    );

    assign m_tdata = {{pitb_pkg::M_PAD_W{1'b0}}, time_ms, slot, result_id};

endmodule

// ----- design/pitb_checker.sv -----
`include "periodic_interval_timer_bank_unit_macros.svh"

module pitb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pitb_pkg::ACT_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pitb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pitb_pkg::KIND_W-1:0]    m_tuser,
    input logic                           m_tlast
);

    // A stalled result holds its payload
    `PITB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Any item that produces results keeps the bank busy in the next cycle
    `PITB_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser != pitb_pkg::ACT_NOP), !s_tready)

    // A fired item always has the tick-done item still to come
    `PITB_ASSERT_NOW(a_fired_not_last, m_tvalid && (m_tuser == pitb_pkg::KIND_FIRED), !m_tlast && !s_tready)

    // Tick-done, set and clear replies close their item
    `PITB_ASSERT_NOW(a_reply_last, m_tvalid && (m_tuser != pitb_pkg::KIND_FIRED), m_tlast)

endmodule

bind periodic_interval_timer_bank_unit pitb_checker u_pitb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
